FILE: rtl/rgbdith_pkg.sv
// Shared widths, defaults and the quantizer level table for the RGB555 error diffusion block.
`default_nettype none

package rgbdith_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int CHAN_W        = 8;
  localparam int CFG_W         = 12;
  localparam int WORD_W        = 15;
  localparam int CODE_W        = 5;
  localparam int ERR_W         = 4;
  localparam int STORE_W       = 8;
  localparam int NUM_CH        = 3;

  typedef logic [CHAN_W-1:0] level_t;

  // Reconstruction level of each 5-bit code, code * 255 / 31 rounded down.
  localparam level_t QUANT_LEVEL [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

endpackage

`default_nettype wire

FILE: rtl/rgbdith_if.sv
// Handshake channel interfaces for pixels in, RGB555 words out and the width register.
`default_nettype none

interface rgbdith_pixel_if import rgbdith_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] red_in;
  logic              start_of_image;

  modport source (output valid, output blue_in, output green_in, output red_in,
                  output start_of_image, input ready);
  modport sink   (input valid, input blue_in, input green_in, input red_in,
                  input start_of_image, output ready);
endinterface

interface rgbdith_word_if import rgbdith_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] pixel_word;
  logic              end_of_row;

  modport source (output valid, output pixel_word, output end_of_row, input ready);
  modport sink   (input valid, input pixel_word, input end_of_row, output ready);
endinterface

interface rgbdith_cfg_if import rgbdith_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rgb888_to_rgb555_error_diffusion.sv
// Top level of the RGB888 to RGB555 converter with Floyd-Steinberg error diffusion.
//
//   Channel     Direction  Payload                                        Transfer
//   pixels      in         blue_in, green_in, red_in, start_of_image      valid & ready
//   words       out        pixel_word, end_of_row                         valid & ready
//   width_cfg   in         data (image_width)                             valid & ready
//
// One pixel per cycle unless the output stalls; a pixel's word is registered after stage one.
// The error of a pixel is registered in stage one and carried to its right neighbor.
// Fill counts mark which line store entries are valid.
// A stalled output word holds while stage one can still take a pixel.
`default_nettype none

module rgb888_to_rgb555_error_diffusion
  import rgbdith_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  rgbdith_cfg_if.sink     width_cfg,
  rgbdith_pixel_if.sink   pixels,
  rgbdith_word_if.source  words
);

  localparam int CW      = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH   = (MAX_WIDTH + 2) / 3;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW      = (CW > CFG_W) ? CW : CFG_W;
  localparam int ENTRY_W = NUM_CH * STORE_W;

  // Width register and effective width.
  logic [CFG_W-1:0] image_width;
  logic [XW-1:0]    width_x;
  logic [CW-1:0]    eff_w;

  assign width_cfg.ready = 1'b1;
  assign width_x = XW'(image_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= CFG_W'(1);
    end else if (width_cfg.valid) begin
      image_width <= width_cfg.data;
    end
  end

  always_comb begin
    if (width_x == '0) begin
      eff_w = CW'(1);
    end else if (width_x > XW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = width_x[CW-1:0];
    end
  end

  // Column tracking for the next pixel.
  logic [CW-1:0] col_cnt;
  logic [AW-1:0] col_div;
  logic [1:0]    col_mod;
  logic          wsel;
  logic [CW-1:0] fill [2];
  logic [CW-1:0] fill_next [2];

  logic          new_row;
  logic [CW-1:0] a_col;
  logic [AW-1:0] a_div;
  logic [1:0]    a_mod;
  logic          a_last;
  logic          a_wsel;

  // Stage one and output registers.
  logic              s1_valid;
  logic [CHAN_W-1:0] s1_pix [NUM_CH];
  logic [CW-1:0]     s1_col;
  logic [AW-1:0]     s1_div;
  logic [1:0]        s1_mod;
  logic              s1_wsel;
  logic              s1_last;
  logic              out_valid;
  logic              s1_move;
  logic              accept;

  assign s1_move      = s1_valid && (!out_valid || words.ready);
  assign pixels.ready = !s1_valid || s1_move;
  assign accept       = pixels.valid && pixels.ready;
  assign words.valid  = out_valid;

  always_comb begin
    new_row = pixels.start_of_image || (col_cnt == '0) || (col_cnt >= eff_w);
    a_col   = new_row ? '0 : col_cnt;
    a_div   = new_row ? '0 : col_div;
    a_mod   = new_row ? 2'd0 : col_mod;
    a_wsel  = new_row ? ~wsel : wsel;
    a_last  = (({1'b0, a_col} + (CW + 1)'(1)) == {1'b0, eff_w});
  end

  // Dithering of the pixel in stage one.
  logic                     rsel;
  logic                     rd_ok;
  logic [ENTRY_W-1:0]       rd_word [2][3];
  logic [ENTRY_W-1:0]       rd_sel;
  logic signed [ERR_W-1:0]  e1 [NUM_CH];
  logic signed [ERR_W-1:0]  e2 [NUM_CH];
  logic signed [ERR_W-1:0]  e1m [NUM_CH];
  logic signed [ERR_W-1:0]  e2m [NUM_CH];
  logic signed [8:0]        acc [NUM_CH];
  logic signed [4:0]        q16 [NUM_CH];
  logic signed [9:0]        sumv [NUM_CH];
  logic [CHAN_W-1:0]        clampv [NUM_CH];
  logic [CODE_W-1:0]        code [NUM_CH];
  logic signed [ERR_W-1:0]  err [NUM_CH];
  logic signed [STORE_W-1:0] ent_l [NUM_CH];
  logic signed [STORE_W-1:0] ent_c [NUM_CH];
  logic signed [STORE_W-1:0] ent_r [NUM_CH];

  assign rsel   = ~s1_wsel;
  assign rd_ok  = s1_col < fill[rsel];
  assign rd_sel = rd_word[rsel][s1_mod];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      e1m[ch] = (s1_col != '0) ? e1[ch] : '0;
      e2m[ch] = (s1_col > CW'(1)) ? e2[ch] : '0;
      acc[ch] = (rd_ok ? 9'($signed(rd_sel[ch*STORE_W +: STORE_W])) : 9'sd0)
              + (9'(e1m[ch]) <<< 3) - 9'(e1m[ch]);
      if (acc[ch] < 0) begin
        q16[ch] = 5'((acc[ch] + 9'sd15) >>> 4);
      end else begin
        q16[ch] = 5'(acc[ch] >>> 4);
      end
      sumv[ch] = $signed({2'b00, s1_pix[ch]}) + 10'(q16[ch]);
      if (sumv[ch] < 0) begin
        clampv[ch] = '0;
      end else if (sumv[ch] > 10'sd255) begin
        clampv[ch] = '1;
      end else begin
        clampv[ch] = sumv[ch][CHAN_W-1:0];
      end
      code[ch]  = clampv[ch][CHAN_W-1:3];
      err[ch]   = ERR_W'($signed({1'b0, clampv[ch]}) - $signed({1'b0, QUANT_LEVEL[code[ch]]}));
      ent_l[ch] = 8'(e2m[ch]) + (8'(e1m[ch]) <<< 2) + 8'(e1m[ch])
                + (8'(err[ch]) <<< 1) + 8'(err[ch]);
      ent_c[ch] = 8'(e1m[ch]) + (8'(err[ch]) <<< 2) + 8'(err[ch]);
      ent_r[ch] = 8'(err[ch]);
    end
  end

  // Write ports of the three column banks of the set being filled.
  logic [1:0]         mod_p1;
  logic [AW-1:0]      waddr [3];
  logic [ENTRY_W-1:0] wdata [3];
  logic               wen [3];

  assign mod_p1 = (s1_mod == 2'd2) ? 2'd0 : s1_mod + 2'd1;

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      if (2'(b) == s1_mod) begin
        waddr[b] = s1_div;
        wen[b]   = 1'b1;
        wdata[b] = {ent_c[2], ent_c[1], ent_c[0]};
      end else if (2'(b) == mod_p1) begin
        waddr[b] = s1_div + ((s1_mod == 2'd2) ? AW'(1) : AW'(0));
        wen[b]   = !s1_last;
        wdata[b] = {ent_r[2], ent_r[1], ent_r[0]};
      end else begin
        waddr[b] = s1_div - ((s1_mod == 2'd0) ? AW'(1) : AW'(0));
        wen[b]   = (s1_col != '0);
        wdata[b] = {ent_l[2], ent_l[1], ent_l[0]};
      end
    end
  end

  for (genvar s = 0; s < 2; s++) begin : g_set
    for (genvar b = 0; b < 3; b++) begin : g_bank
      logic [ENTRY_W-1:0] mem [DEPTH];
      logic [ENTRY_W-1:0] rdata;
      logic               we;

      assign we = s1_move && (s1_wsel == 1'(s)) && wen[b];
      assign rd_word[s][b] = rdata;

      always_ff @(posedge clk) begin
        if (we) begin
          mem[waddr[b]] <= wdata[b];
        end
        if (accept) begin
          if (we && (waddr[b] == a_div)) begin
            rdata <= wdata[b];
          end else begin
            rdata <= mem[a_div];
          end
        end
      end
    end
  end

  always_comb begin
    fill_next[0] = fill[0];
    fill_next[1] = fill[1];
    if (s1_move) begin
      fill_next[s1_wsel] = s1_last ? CW'({1'b0, s1_col} + (CW + 1)'(1))
                                   : CW'({1'b0, s1_col} + (CW + 1)'(2));
    end
    if (accept && new_row) begin
      fill_next[a_wsel] = '0;
      if (pixels.start_of_image) begin
        fill_next[~a_wsel] = '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      col_div   <= '0;
      col_mod   <= 2'd0;
      wsel      <= 1'b0;
      fill[0]   <= '0;
      fill[1]   <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fill[0] <= fill_next[0];
      fill[1] <= fill_next[1];
      if (accept) begin
        wsel <= a_wsel;
        if (a_last) begin
          col_cnt <= '0;
          col_div <= '0;
          col_mod <= 2'd0;
        end else begin
          col_cnt <= a_col + CW'(1);
          if (a_mod == 2'd2) begin
            col_div <= a_div + AW'(1);
            col_mod <= 2'd0;
          end else begin
            col_div <= a_div;
            col_mod <= a_mod + 2'd1;
          end
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix[0] <= pixels.blue_in;
      s1_pix[1] <= pixels.green_in;
      s1_pix[2] <= pixels.red_in;
      s1_col    <= a_col;
      s1_div    <= a_div;
      s1_mod    <= a_mod;
      s1_wsel   <= a_wsel;
      s1_last   <= a_last;
    end
    if (s1_move) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        e1[ch] <= err[ch];
        e2[ch] <= e1[ch];
      end
      words.pixel_word <= {code[2], code[1], code[0]};
      words.end_of_row <= s1_last;
    end
  end

  // A start of image always places its pixel in column zero.
  a_sof_col0: assert property (@(posedge clk) disable iff (rst)
    accept && pixels.start_of_image |=> s1_valid && (s1_col == '0))
    else $error("start of image pixel not placed in column zero");

  // The pixel at work lies inside the effective row width.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_col < eff_w))
    else $error("stage one column beyond the row width");

  // Input stalls only when both stages are full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> s1_valid && out_valid && !words.ready)
    else $error("input stalled without a full pipeline");

  // A pixel leaving stage one shows up as a word with its row end mark.
  a_word_eor: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> words.valid && (words.end_of_row == $past(s1_last)))
    else $error("output word lost or row end mark wrong");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the RGB888 to RGB555 error diffusion converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbdith_pkg::*;

  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              eor;
  } word_t;

  logic clk;
  logic rst;

  rgbdith_cfg_if   cfg_ch ();
  rgbdith_pixel_if pix_ch ();
  rgbdith_word_if  word_ch ();

  rgb888_to_rgb555_error_diffusion u_dut (
    .clk       (clk),
    .rst       (rst),
    .width_cfg (cfg_ch),
    .pixels    (pix_ch),
    .words     (word_ch)
  );

  logic signed [STORE_W-1:0] cur_err [NUM_CH*MAX_WIDTH_DEF];
  logic signed [STORE_W-1:0] nxt_err [NUM_CH*MAX_WIDTH_DEF];
  int          col_cnt;
  logic [CFG_W-1:0] cfg_width;

  word_t expected_words [$];
  word_t want;
  int    err_count;
  int    n_pixels;
  int    n_words;
  int    n_cfg;
  int    quiet_cycles = 0;
  bit    gaps_on;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, exp_val);
    err_count++;
  endtask

  function automatic void close_row();
    cur_err = nxt_err;
    nxt_err = '{default: '0};
    col_cnt = 0;
  endfunction

  function automatic logic [CODE_W-1:0] dither_chan(input int value, input int col,
                                                    input int w, input int ch);
    int idx;
    int v;
    int q;
    int e;
    idx = col * NUM_CH + ch;
    v = value + int'(cur_err[idx]) / 16;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    q = v >> 3;
    e = v - (q * 255) / 31;
    nxt_err[idx] = STORE_W'(int'(nxt_err[idx]) + 5 * e);
    if (col + 1 < w) begin
      cur_err[idx + NUM_CH] = STORE_W'(int'(cur_err[idx + NUM_CH]) + 7 * e);
      nxt_err[idx + NUM_CH] = STORE_W'(int'(nxt_err[idx + NUM_CH]) + e);
    end
    if (col >= 1)
      nxt_err[idx - NUM_CH] = STORE_W'(int'(nxt_err[idx - NUM_CH]) + 3 * e);
    return q[CODE_W-1:0];
  endfunction

  function automatic void predict_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                                        input logic [CHAN_W-1:0] r, input logic sof);
    int w;
    int col;
    logic [CODE_W-1:0] b5;
    logic [CODE_W-1:0] g5;
    logic [CODE_W-1:0] r5;
    word_t res;
    if (sof) begin
      cur_err = '{default: '0};
      nxt_err = '{default: '0};
      col_cnt = 0;
    end
    w = cfg_width;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (col_cnt >= w) close_row();
    col = col_cnt;
    b5 = dither_chan(b, col, w, CH_BLUE);
    g5 = dither_chan(g, col, w, CH_GREEN);
    r5 = dither_chan(r, col, w, CH_RED);
    res.word = {r5, g5, b5};
    res.eor  = (col + 1 == w);
    if (res.eor) close_row();
    else col_cnt = col + 1;
    expected_words.push_back(res);
  endfunction

  function automatic logic [CHAN_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return CHAN_W'($urandom_range(0, 7));
      3: return CHAN_W'($urandom_range(248, 255));
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] r, input logic sof);
    if (gaps_on && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 18)) @(negedge clk);
    pix_ch.blue_in        = b;
    pix_ch.green_in       = g;
    pix_ch.red_in         = r;
    pix_ch.start_of_image = sof;
    pix_ch.valid          = 1'b1;
    do @(posedge clk); while (!pix_ch.ready);
    predict_pixel(b, g, r, sof);
    n_pixels++;
    @(negedge clk);
    pix_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_width(input int w);
    wait_drained();
    cfg_ch.data  = CFG_W'(w);
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_width = CFG_W'(w);
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_random_row(input int count, input logic sof_first);
    for (int k = 0; k < count; k++)
      send_pixel(rand_level(), rand_level(), rand_level(), (k == 0) ? sof_first : 1'b0);
  endtask

  task automatic test_default_and_zero_width();
    send_pixel(8'h00, 8'hFF, 8'h80, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'h7F, 1'b0);
    write_width(0);
    send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
  endtask

  task automatic test_field_extremes();
    write_width(4);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h04, 8'hFB, 8'h07, 1'b0);
    send_pixel(8'hFC, 8'h03, 8'hF9, 1'b0);
    send_pixel(8'h07, 8'h07, 8'h07, 1'b0);
    send_pixel(8'hFE, 8'hFE, 8'hFE, 1'b0);
    send_pixel(8'h01, 8'h02, 8'h06, 1'b0);
    send_pixel(8'hFD, 8'hFA, 8'hF8, 1'b0);
    send_pixel(8'h11, 8'h22, 8'h33, 1'b1);
  endtask

  task automatic test_width_changes();
    write_width(6);
    send_random_row(4, 1'b1);
    write_width(2);
    send_random_row(3, 1'b0);
    write_width(3);
    send_random_row(1, 1'b0);
    write_width(5);
    send_random_row(4, 1'b0);
  endtask

  task automatic test_widest_rows();
    write_width(MAX_WIDTH_DEF);
    send_random_row(100, 1'b1);
    write_width((1 << CFG_W) - 1);
    send_random_row(100, 1'b0);
  endtask

  task automatic test_random_images();
    int sent;
    int width;
    int rows;
    int total;
    logic sof;
    sent = 0;
    while (sent < 560) begin
      case ($urandom_range(0, 9))
        0: width = 0;
        1: width = 1;
        2: width = 2;
        3: width = $urandom_range(41, 200);
        default: width = $urandom_range(3, 40);
      endcase
      write_width(width);
      rows = (width > 40) ? 1 : $urandom_range(1, 5);
      total = ((width == 0) ? 1 : width) * rows;
      if ($urandom_range(0, 5) == 0) total += $urandom_range(1, 7);
      for (int k = 0; k < total; k++) begin
        if (k == 0) sof = ($urandom_range(0, 7) != 0);
        else sof = ($urandom_range(0, 59) == 0);
        send_pixel(rand_level(), rand_level(), rand_level(), sof);
      end
      sent += total;
    end
  endtask

  task automatic test_back_to_back();
    wait_drained();
    gaps_on = 1'b0;
    write_width($urandom_range(3, 12));
    send_random_row(60, 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int stall;
    stall = 0;
    word_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        word_ch.ready = 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 15) == 0) begin
        word_ch.ready = 1'b0;
        stall = $urandom_range(1, 18) - 1;
      end else begin
        word_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && word_ch.valid && word_ch.ready) begin
      n_words++;
      if (expected_words.size() == 0) begin
        report_mismatch("word with no pixel pending", word_ch.pixel_word, 0);
      end else begin
        want = expected_words.pop_front();
        if (word_ch.pixel_word !== want.word)
          report_mismatch("pixel_word", word_ch.pixel_word, want.word);
        if (word_ch.end_of_row !== want.eor)
          report_mismatch("end_of_row", word_ch.end_of_row, want.eor);
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (word_ch.valid && word_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no transfer", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                   = 1'b1;
    pix_ch.valid          = 1'b0;
    pix_ch.blue_in        = '0;
    pix_ch.green_in       = '0;
    pix_ch.red_in         = '0;
    pix_ch.start_of_image = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.data           = '0;
    cur_err               = '{default: '0};
    nxt_err               = '{default: '0};
    col_cnt               = 0;
    cfg_width             = CFG_W'(1);
    err_count             = 0;
    n_pixels              = 0;
    n_words               = 0;
    n_cfg                 = 0;
    gaps_on               = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_default_and_zero_width();
    test_field_extremes();
    test_width_changes();
    test_widest_rows();
    test_random_images();
    test_back_to_back();

    wait_drained();
    repeat (8) @(negedge clk);
    if (expected_words.size() != 0)
      report_mismatch("words never produced", 0, expected_words.size());
    $display("%0d pixels sent, %0d words checked, %0d width writes", n_pixels, n_words, n_cfg);
    $display("widths 0 to 4095, mid-row width changes, image restarts and clamped levels");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", err_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
